FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clk edge outside reset.
`define RCMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that cons holds in the cycle after ante.
`define RCMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/rcms_pkg.sv
`timescale 1ns / 1ps

package rcms_pkg;

  localparam int MAX_ROWS  = 8;
  localparam int MAX_COLS  = 8;
  localparam int CELL_BITS = 8;

  localparam int STORE_DIM = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int IDX_W     = $clog2(STORE_DIM);
  // one bank bit on top of row and column
  localparam int ADDR_W    = 1 + 2 * IDX_W;
  localparam int RAM_DEPTH = 2 * STORE_DIM * STORE_DIM;

  localparam int FUNC_W = 3;
  localparam int FIDX_W = 3;
  localparam int CNT_W  = 4;
  localparam int VAL_W  = 8;

  localparam logic [CELL_BITS-1:0] EMPTY_CELL = '1;

  typedef enum logic [FUNC_W-1:0] {
    FN_READ  = 3'd0,
    FN_WRITE = 3'd1,
    FN_ROTL  = 3'd2,
    FN_ROTR  = 3'd3,
    FN_SCAN  = 3'd4
  } func_t;

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  typedef struct packed {
    logic                 we;
    logic [ADDR_W-1:0]    waddr;
    logic [CELL_BITS-1:0] wdata;
    logic [ADDR_W-1:0]    raddr;
  } ram_req_t;

  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
                                                   input logic [CNT_W-1:0] hi);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // sign-extend a stored cell to the output width
  function automatic logic [VAL_W-1:0] cell_to_out(input logic [CELL_BITS-1:0] c);
    logic signed [CELL_BITS-1:0] s;
    logic signed [VAL_W-1:0]     w;
    s = $signed(c);
    w = VAL_W'(s);
    return w;
  endfunction

endpackage

FILE: design/rcms_if.sv
`timescale 1ns / 1ps

interface rcms_req_if
  import rcms_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic [FIDX_W-1:0]        row_index;
  logic [FIDX_W-1:0]        col_index;
  logic signed [VAL_W-1:0]  cell_value;

  modport source (output valid, func, row_index, col_index, cell_value, input ready);
  modport sink   (input valid, func, row_index, col_index, cell_value, output ready);
endinterface

interface rcms_rsp_if
  import rcms_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [VAL_W-1:0]  read_value;
  logic [CNT_W-1:0]         lower_row;
  logic [CNT_W-1:0]         rows_now;
  logic [CNT_W-1:0]         cols_now;
  logic                     out_of_range;

  modport source (output valid, read_value, lower_row, rows_now, cols_now, out_of_range,
                  input ready);
  modport sink   (input valid, read_value, lower_row, rows_now, cols_now, out_of_range,
                  output ready);
endinterface

FILE: design/rcms_cell_ram.sv
`timescale 1ns / 1ps

module rcms_cell_ram
  import rcms_pkg::*;
(
  input  logic                 clk,
  input  ram_req_t             ram_req,
  output logic [CELL_BITS-1:0] rdata
);

  logic [CELL_BITS-1:0] mem [RAM_DEPTH];

  always_ff @(posedge clk) begin
    if (ram_req.we) begin
      mem[ram_req.waddr] <= ram_req.wdata;
    end
    rdata <= mem[ram_req.raddr];
  end

endmodule

FILE: design/rcms_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rcms_ctrl
  import rcms_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  rcms_req_if.sink             req,
  rcms_rsp_if.source           rsp,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [CNT_W-1:0]     cfg_data,
  output ram_req_t             ram_req,
  input  logic [CELL_BITS-1:0] ram_rdata
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ_ISSUE,
    ST_READ_DATA,
    ST_SCAN_ISSUE,
    ST_SCAN_DATA,
    ST_ROT,
    ST_ROT_DRAIN,
    ST_FINISH
  } state_t;

  state_t                 state;
  logic                   bank;
  logic [CNT_W-1:0]       rows;
  logic [CNT_W-1:0]       cols;

  func_t                  item_func;
  logic [IDX_W-1:0]       item_row;
  logic [IDX_W-1:0]       item_col;

  logic [IDX_W-1:0]       scan_row;
  logic [2*IDX_W-1:0]     rot_cnt;
  logic                   wr_pend;
  logic [2*IDX_W-1:0]     wr_dst;

  logic [VAL_W-1:0]       res_read;
  logic [CNT_W-1:0]       res_low;
  logic                   res_oor;

  logic                   out_valid;
  logic [VAL_W-1:0]       out_read;
  logic [CNT_W-1:0]       out_low;
  logic [CNT_W-1:0]       out_rows;
  logic [CNT_W-1:0]       out_cols;
  logic                   out_oor;

  logic                   accept;
  func_t                  in_func;
  logic [IDX_W-1:0]       in_row;
  logic [IDX_W-1:0]       in_col;
  logic                   in_inside;

  logic [IDX_W-1:0]       rot_i;
  logic [IDX_W-1:0]       rot_j;
  logic                   rot_live;
  logic [IDX_W-1:0]       src_row;
  logic [IDX_W-1:0]       src_col;
  logic                   scan_last;
  logic                   out_free;

  assign accept    = req.valid && req.ready;
  assign in_func   = func_t'(req.func);
  assign in_row    = IDX_W'(req.row_index);
  assign in_col    = IDX_W'(req.col_index);
  assign in_inside = (CNT_W'(req.row_index) < rows) && (CNT_W'(req.col_index) < cols);

  assign req.ready = (state == ST_IDLE);
  assign out_free  = !out_valid || rsp.ready;
  assign scan_last = (CNT_W'(scan_row) + CNT_W'(1)) >= rows;

  // rotation walks every destination cell; cells outside the new size copy across
  assign rot_i    = rot_cnt[2*IDX_W-1:IDX_W];
  assign rot_j    = rot_cnt[IDX_W-1:0];
  assign rot_live = (CNT_W'(rot_i) < cols) && (CNT_W'(rot_j) < rows);

  always_comb begin
    src_row = rot_i;
    src_col = rot_j;
    if (rot_live) begin
      if (item_func == FN_ROTL) begin
        src_row = IDX_W'(rows - CNT_W'(1) - CNT_W'(rot_j));
        src_col = rot_i;
      end else begin
        src_row = rot_j;
        src_col = IDX_W'(cols - CNT_W'(1) - CNT_W'(rot_i));
      end
    end
  end

  always_comb begin
    ram_req.we    = 1'b0;
    ram_req.waddr = {bank, in_row, in_col};
    ram_req.wdata = CELL_BITS'(req.cell_value);
    if (wr_pend) begin
      ram_req.we    = 1'b1;
      ram_req.waddr = {~bank, wr_dst};
      ram_req.wdata = ram_rdata;
    end else if (accept && in_func == FN_WRITE && in_inside) begin
      ram_req.we = 1'b1;
    end

    unique case (state)
      ST_ROT:        ram_req.raddr = {bank, src_row, src_col};
      ST_SCAN_ISSUE: ram_req.raddr = {bank, scan_row, item_col};
      default:       ram_req.raddr = {bank, item_row, item_col};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      bank      <= 1'b0;
      rows      <= clamp_count(CNT_W'(8), CNT_W'(MAX_ROWS));
      cols      <= clamp_count(CNT_W'(8), CNT_W'(MAX_COLS));
      wr_pend   <= 1'b0;
      out_valid <= 1'b0;
      rot_cnt   <= '0;
    end else begin
      wr_pend <= (state == ST_ROT);
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_we) begin
        if (cfg_index == CFG_ROWS) begin
          rows <= clamp_count(cfg_data, CNT_W'(MAX_ROWS));
        end else begin
          cols <= clamp_count(cfg_data, CNT_W'(MAX_COLS));
        end
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            item_func <= in_func;
            item_row  <= in_row;
            item_col  <= in_col;
            scan_row  <= in_row;
            res_read  <= '0;
            res_low   <= '0;
            res_oor   <= 1'b0;
            rot_cnt   <= '0;
            unique case (in_func)
              FN_READ: begin
                if (in_inside) begin
                  state <= ST_READ_ISSUE;
                end else begin
                  res_oor <= 1'b1;
                  state   <= ST_FINISH;
                end
              end
              FN_WRITE: begin
                res_oor <= !in_inside;
                state   <= ST_FINISH;
              end
              FN_ROTL, FN_ROTR: begin
                state <= ST_ROT;
              end
              FN_SCAN: begin
                if (CNT_W'(req.col_index) >= cols) begin
                  res_low <= rows;
                  res_oor <= 1'b1;
                  state   <= ST_FINISH;
                end else if (CNT_W'(req.row_index) >= rows) begin
                  res_low <= rows;
                  state   <= ST_FINISH;
                end else begin
                  state <= ST_SCAN_ISSUE;
                end
              end
              default: begin
                state <= ST_FINISH;
              end
            endcase
          end
        end
        ST_READ_ISSUE: begin
          state <= ST_READ_DATA;
        end
        ST_READ_DATA: begin
          res_read <= cell_to_out(ram_rdata);
          state    <= ST_FINISH;
        end
        ST_SCAN_ISSUE: begin
          state <= ST_SCAN_DATA;
        end
        ST_SCAN_DATA: begin
          if (ram_rdata != EMPTY_CELL) begin
            res_low <= CNT_W'(scan_row);
            state   <= ST_FINISH;
          end else if (scan_last) begin
            res_low <= rows;
            state   <= ST_FINISH;
          end else begin
            scan_row <= scan_row + IDX_W'(1);
            state    <= ST_SCAN_ISSUE;
          end
        end
        ST_ROT: begin
          wr_dst  <= rot_cnt;
          rot_cnt <= rot_cnt + (2*IDX_W)'(1);
          if (rot_cnt == '1) begin
            state <= ST_ROT_DRAIN;
          end
        end
        ST_ROT_DRAIN: begin
          bank  <= ~bank;
          rows  <= cols;
          cols  <= rows;
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_read  <= res_read;
            out_low   <= res_low;
            out_rows  <= rows;
            out_cols  <= cols;
            out_oor   <= res_oor;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.read_value   = $signed(out_read);
  assign rsp.lower_row    = out_low;
  assign rsp.rows_now     = out_rows;
  assign rsp.cols_now     = out_cols;
  assign rsp.out_of_range = out_oor;

  `RCMS_ASSERT(a_rows_legal, (rows >= CNT_W'(1)) && (rows <= CNT_W'(STORE_DIM)), "row count out of range")
  `RCMS_ASSERT(a_cols_legal, (cols >= CNT_W'(1)) && (cols <= CNT_W'(STORE_DIM)), "col count out of range")
  `RCMS_ASSERT(a_rot_other_bank, wr_pend |-> (ram_req.we && (ram_req.waddr[ADDR_W-1] != bank)), "rotation write hit live bank")
  `RCMS_ASSERT_NEXT(a_bank_flip, state == ST_ROT_DRAIN, bank != $past(bank), "bank did not flip after rotation")
  `RCMS_ASSERT(a_load_from_finish, $rose(out_valid) |-> $past(state == ST_FINISH), "result loaded outside finish")

endmodule

FILE: design/rotatable_cell_matrix_store.sv
// channel | dir | handshake   | word
// req     | in  | valid/ready | func, row_index, col_index, cell_value
// rsp     | out | valid/ready | read_value, lower_row, rows_now, cols_now, out_of_range
// cfg     | in  | cfg_we      | cfg_index, cfg_data (no read-back)
//
// Write goes to finish, read issues then takes data, scan reads row by row; rotate makes
// one cell RAM access per cycle over all 64 cells of the 8x8 store, plus fill/drain.
// Reset: counts at 8x8, bank 0, cell RAM contents undefined, no clearing pass.
// One output register: a new word is taken while a result waits; that word then
// holds in its final step until rsp is free.
`timescale 1ns / 1ps

module rotatable_cell_matrix_store
  import rcms_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  rcms_req_if.sink         req,
  rcms_rsp_if.source       rsp,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CNT_W-1:0] cfg_data
);

  ram_req_t             ram_req;
  logic [CELL_BITS-1:0] ram_rdata;

  rcms_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  rcms_cell_ram u_ram (
    .clk     (clk),
    .ram_req (ram_req),
    .rdata   (ram_rdata)
  );

endmodule
